>>> rtl/glfs_pkg.sv
// Shared types and constants for the gamepad link frame sender.
`timescale 1ns / 1ps
package glfs_pkg;

    typedef struct packed {
        logic [15:0] button_bits;
        logic [7:0]  hat_value;
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
        logic [15:0] right_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [7:0]  mode_code;
        logic [31:0] time_ms;
    } t_glfs_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_kind;
        logic       last_of_run;
    } t_glfs_out;

    typedef struct packed {
        logic [7:0]  frame_magic;
        logic [7:0]  frame_version;
        logic [7:0]  input_frame_type;
        logic [7:0]  status_frame_type;
        logic [15:0] input_refresh_ms;
        logic [15:0] status_refresh_ms;
    } t_glfs_cfg;

    // One queued request: which frames to send and the values they carry.
    typedef struct packed {
        logic        send_in;
        logic        send_st;
        logic [15:0] button_bits;
        logic [7:0]  hat_value;
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
        logic [15:0] right_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [7:0]  mode_code;
    } t_glfs_job;

    typedef struct packed {
        logic      valid;
        t_glfs_job job;
    } t_glfs_push;

    typedef enum logic [2:0] {
        CFG_MAGIC      = 3'd0,
        CFG_VERSION    = 3'd1,
        CFG_IN_TYPE    = 3'd2,
        CFG_ST_TYPE    = 3'd3,
        CFG_IN_REFRESH = 3'd4,
        CFG_ST_REFRESH = 3'd5
    } t_glfs_cfg_idx;

    localparam int IDX_W = 5;

    localparam logic [IDX_W-1:0] IN_LAST_IDX = 5'd18;
    localparam logic [IDX_W-1:0] ST_LAST_IDX = 5'd23;

    localparam logic [7:0]  IN_PAYLOAD_LEN = 8'd13;
    localparam logic [7:0]  ST_PAYLOAD_LEN = 8'd18;
    localparam logic [7:0]  ST_FIVE        = 8'd5;
    localparam logic [7:0]  ST_ALL_ONES    = 8'hFF;
    localparam logic [15:0] ST_WORD_4200   = 16'd4200;
    localparam logic [7:0]  ST_TAIL        = 8'h03;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0]  RST_MAGIC      = 8'd170;
    localparam logic [7:0]  RST_VERSION    = 8'd1;
    localparam logic [7:0]  RST_IN_TYPE    = 8'd1;
    localparam logic [7:0]  RST_ST_TYPE    = 8'd2;
    localparam logic [15:0] RST_IN_REFRESH = 16'd50;
    localparam logic [15:0] RST_ST_REFRESH = 16'd1000;
    localparam logic [7:0]  RST_PREV_MODE  = 8'hFF;

endpackage

>>> rtl/glfs_front.sv
// Front end: takes polls, decides which frames are due, keeps the last-sent copy.
`timescale 1ns / 1ps
module glfs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  glfs_pkg::t_glfs_cfg i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  glfs_pkg::t_glfs_in  i_in_data,
    input  logic               i_push_ready,
    output glfs_pkg::t_glfs_push o_push
);
    import glfs_pkg::*;

    logic [15:0] r_buttons;
    logic [7:0]  r_hat;
    logic [15:0] r_lx, r_ly, r_rx, r_ry;
    logic [7:0]  r_lt, r_rt;
    logic [31:0] r_in_time;
    logic [7:0]  r_mode;
    logic [31:0] r_st_time;

    logic        accept;
    logic        changed;
    logic        send_in;
    logic        send_st;
    logic [31:0] in_elapsed;
    logic [31:0] st_elapsed;

    assign o_in_ready = i_push_ready;
    assign accept     = i_in_valid && i_push_ready;

    assign changed = (i_in_data.button_bits   != r_buttons) ||
                     (i_in_data.hat_value     != r_hat)     ||
                     (i_in_data.left_x        != r_lx)      ||
                     (i_in_data.left_y        != r_ly)      ||
                     (i_in_data.right_x       != r_rx)      ||
                     (i_in_data.right_y       != r_ry)      ||
                     (i_in_data.left_trigger  != r_lt)      ||
                     (i_in_data.right_trigger != r_rt);

    // elapsed time wraps modulo 2^32
    assign in_elapsed = i_in_data.time_ms - r_in_time;
    assign st_elapsed = i_in_data.time_ms - r_st_time;

    assign send_in = changed || (in_elapsed >= {16'd0, i_cfg.input_refresh_ms});
    assign send_st = (i_in_data.mode_code != r_mode) ||
                     (st_elapsed >= {16'd0, i_cfg.status_refresh_ms});

    always_comb begin
        o_push.valid             = accept && (send_in || send_st);
        o_push.job.send_in       = send_in;
        o_push.job.send_st       = send_st;
        o_push.job.button_bits   = i_in_data.button_bits;
        o_push.job.hat_value     = i_in_data.hat_value;
        o_push.job.left_x        = i_in_data.left_x;
        o_push.job.left_y        = i_in_data.left_y;
        o_push.job.right_x       = i_in_data.right_x;
        o_push.job.right_y       = i_in_data.right_y;
        o_push.job.left_trigger  = i_in_data.left_trigger;
        o_push.job.right_trigger = i_in_data.right_trigger;
        o_push.job.mode_code     = i_in_data.mode_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buttons <= '0;
            r_hat     <= '0;
            r_lx      <= '0;
            r_ly      <= '0;
            r_rx      <= '0;
            r_ry      <= '0;
            r_lt      <= '0;
            r_rt      <= '0;
            r_in_time <= '0;
            r_mode    <= RST_PREV_MODE;
            r_st_time <= '0;
        end else if (accept) begin
            if (send_in) begin
                r_buttons <= i_in_data.button_bits;
                r_hat     <= i_in_data.hat_value;
                r_lx      <= i_in_data.left_x;
                r_ly      <= i_in_data.left_y;
                r_rx      <= i_in_data.right_x;
                r_ry      <= i_in_data.right_y;
                r_lt      <= i_in_data.left_trigger;
                r_rt      <= i_in_data.right_trigger;
                r_in_time <= i_in_data.time_ms;
            end
            if (send_st) begin
                r_mode    <= i_in_data.mode_code;
                r_st_time <= i_in_data.time_ms;
            end
        end
    end

endmodule

>>> rtl/glfs_fifo.sv
// Small register queue of frame requests between front and back end.
`timescale 1ns / 1ps
module glfs_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  glfs_pkg::t_glfs_push i_push,
    output logic                 o_push_ready,
    output logic                 o_head_valid,
    output glfs_pkg::t_glfs_job  o_head,
    input  logic                 i_pop
);
    import glfs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_glfs_job        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && o_push_ready;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/glfs_back.sv
// Back end: serializes queued requests into framed bytes with a running CRC-16.
`timescale 1ns / 1ps
module glfs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  glfs_pkg::t_glfs_cfg i_cfg,
    input  logic                i_head_valid,
    input  glfs_pkg::t_glfs_job i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output glfs_pkg::t_glfs_out o_out_data
);
    import glfs_pkg::*;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

    logic [IDX_W-1:0] r_idx;
    logic             r_mid;      // input frame done, status frame of same request next
    logic [15:0]      r_crc;
    logic             r_out_valid;
    t_glfs_out        r_out;

    logic             kind;
    logic [IDX_W-1:0] last_idx;
    logic             at_last;
    logic             can_adv;
    logic             emit;
    logic             in_crc;
    logic [7:0]       cur_byte;

    assign kind     = r_mid || !i_head.send_in;
    assign last_idx = kind ? ST_LAST_IDX : IN_LAST_IDX;
    assign at_last  = (r_idx == last_idx);
    assign can_adv  = !r_out_valid || i_out_ready;
    assign emit     = i_head_valid && can_adv;
    assign o_pop    = emit && at_last && (kind || !i_head.send_st);
    // CRC covers everything after magic and before the two CRC bytes
    assign in_crc   = (r_idx != '0) && (r_idx < last_idx - 5'd1);

    always_comb begin
        cur_byte = 8'h00;
        if (r_idx == '0) begin
            cur_byte = i_cfg.frame_magic;
        end else if (r_idx == 5'd1) begin
            cur_byte = i_cfg.frame_version;
        end else if (r_idx == last_idx - 5'd1) begin
            cur_byte = r_crc[7:0];
        end else if (at_last) begin
            cur_byte = r_crc[15:8];
        end else if (!kind) begin
            case (r_idx)
                5'd2:    cur_byte = i_cfg.input_frame_type;
                5'd3:    cur_byte = IN_PAYLOAD_LEN;
                5'd4:    cur_byte = i_head.button_bits[7:0];
                5'd5:    cur_byte = i_head.button_bits[15:8];
                5'd6:    cur_byte = i_head.hat_value;
                5'd7:    cur_byte = i_head.left_x[7:0];
                5'd8:    cur_byte = i_head.left_x[15:8];
                5'd9:    cur_byte = i_head.left_y[7:0];
                5'd10:   cur_byte = i_head.left_y[15:8];
                5'd11:   cur_byte = i_head.right_x[7:0];
                5'd12:   cur_byte = i_head.right_x[15:8];
                5'd13:   cur_byte = i_head.right_y[7:0];
                5'd14:   cur_byte = i_head.right_y[15:8];
                5'd15:   cur_byte = i_head.left_trigger;
                5'd16:   cur_byte = i_head.right_trigger;
                default: cur_byte = 8'h00;
            endcase
        end else begin
            case (r_idx)
                5'd2:    cur_byte = i_cfg.status_frame_type;
                5'd3:    cur_byte = ST_PAYLOAD_LEN;
                5'd6:    cur_byte = i_head.mode_code;
                5'd8:    cur_byte = ST_FIVE;
                5'd10:   cur_byte = ST_ALL_ONES;
                5'd19:   cur_byte = ST_WORD_4200[7:0];
                5'd20:   cur_byte = ST_WORD_4200[15:8];
                5'd21:   cur_byte = ST_TAIL;
                default: cur_byte = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.tx_byte     <= cur_byte;
            r_out.frame_kind  <= kind;
            r_out.last_of_run <= o_pop;
            if (r_idx == '0) begin
                r_crc <= CRC_INIT;
            end else if (in_crc) begin
                r_crc <= crc_byte(r_crc, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_mid       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (at_last) begin
                    r_idx <= '0;
                    r_mid <= !kind && i_head.send_st;
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/gamepad_link_frame_sender_core.sv
// Top level of the gamepad link frame sender: config registers, front, queue, back.
`timescale 1ns / 1ps
// Usage:
// - Input channel (i_in_valid / o_in_ready / i_in_data) takes one controller poll
//   per request. The poll is compared with the last-sent copy and a frame request
//   is queued; polls with nothing due leave no trace on the output.
// - Output channel (o_out_valid / i_out_ready / o_out_data) gives one frame byte
//   per request: 19 bytes for an input frame, 24 for a status frame, 43 when both
//   are due. last_of_run marks the final byte caused by a poll.
// - With the queue empty, an accepted poll is first written into the queue, then its
//   first byte is loaded into the output register and o_out_valid rises; the back
//   end then sends one byte per cycle while i_out_ready is high. The byte serializer
//   sets the sustained rate.
// - A queue of FIFO_DEPTH requests sits between the sides, so polls are taken while
//   earlier frames still stream out; o_in_ready drops only when it is full.
// - When i_out_ready is low the byte held in the output register stays put and
//   serialization pauses.
// - Reset (i_rst_n low, synchronous) restores default config, clears the stored
//   poll copy and timestamps (mode copy to 0xFF) and empties the queue.
// - Config writes (i_cfg_wr_en) take effect at once and are meant for idle time.
module gamepad_link_frame_sender_core #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  glfs_pkg::t_glfs_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output glfs_pkg::t_glfs_out o_out_data
);
    import glfs_pkg::*;

    t_glfs_cfg  r_cfg;
    t_glfs_push push;
    logic       push_ready;
    logic       head_valid;
    t_glfs_job  head;
    logic       pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_magic       <= RST_MAGIC;
            r_cfg.frame_version     <= RST_VERSION;
            r_cfg.input_frame_type  <= RST_IN_TYPE;
            r_cfg.status_frame_type <= RST_ST_TYPE;
            r_cfg.input_refresh_ms  <= RST_IN_REFRESH;
            r_cfg.status_refresh_ms <= RST_ST_REFRESH;
        end else if (i_cfg_wr_en) begin
            case (t_glfs_cfg_idx'(i_cfg_index))
                CFG_MAGIC:      r_cfg.frame_magic       <= i_cfg_wdata[7:0];
                CFG_VERSION:    r_cfg.frame_version     <= i_cfg_wdata[7:0];
                CFG_IN_TYPE:    r_cfg.input_frame_type  <= i_cfg_wdata[7:0];
                CFG_ST_TYPE:    r_cfg.status_frame_type <= i_cfg_wdata[7:0];
                CFG_IN_REFRESH: r_cfg.input_refresh_ms  <= i_cfg_wdata;
                CFG_ST_REFRESH: r_cfg.status_refresh_ms <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    glfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_push_ready (push_ready),
        .o_push       (push)
    );

    glfs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    glfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

>>> rtl/glfs_checker.sv
// Port-level assertions for the frame sender, bound to the top level.
`timescale 1ns / 1ps
module glfs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input glfs_pkg::t_glfs_out o_out_data
);
    import glfs_pkg::*;

    // after reset the queue is empty and nothing is pending on the output
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("output busy or input blocked right after reset");

    // a stalled byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output byte changed while stalled");

    // inside a status frame, the next byte shown belongs to the same frame
    a_status_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.frame_kind && !o_out_data.last_of_run)
        |=> (!o_out_valid || o_out_data.frame_kind))
        else $error("status frame cut short by another frame");

endmodule

bind gamepad_link_frame_sender_core glfs_checker u_glfs_checker (.*);
